### hw/rtl/glws_pkg.sv
// Package with the types and constants of the gaze link watchdog and smoother.
package glws_pkg;

  // Register byte addresses on the configuration port.
  localparam int unsigned CFG_AW = 4;
  localparam logic [CFG_AW-1:0] ADDR_EXPECTED_MAGIC = 4'h0;
  localparam logic [CFG_AW-1:0] ADDR_STALE_LIMIT    = 4'h4;
  localparam logic [CFG_AW-1:0] ADDR_SMOOTHING_GAIN = 4'h8;

  // Register reset values.
  localparam logic [31:0] EXPECTED_MAGIC_RST = 32'd0;
  localparam logic [7:0]  STALE_LIMIT_RST    = 8'd30;
  localparam logic [16:0] SMOOTHING_GAIN_RST = 17'd13107;

  // Fixed point constants: axis 1.0 in Q2.14 and unity gain.
  localparam logic signed [15:0] AXIS_POS_ONE = 16'sd16384;
  localparam logic signed [15:0] AXIS_NEG_ONE = -16'sd16384;
  localparam logic [16:0]        GAIN_ONE     = 17'd65536;

  // One registered input transaction.
  typedef struct packed {
    logic               source_present;
    logic               packet_valid;
    logic [31:0]        magic_word;
    logic [31:0]        frame_id;
    logic signed [15:0] gaze_x;
    logic signed [15:0] gaze_y;
    logic signed [15:0] head_z;
  } glws_in_t;

  // One result transaction.
  typedef struct packed {
    logic               link_up;
    logic               magic_match;
    logic               valid_seen;
    logic signed [15:0] smooth_x;
    logic signed [15:0] smooth_y;
    logic signed [15:0] smooth_z;
    logic [31:0]        raw_frame;
  } glws_out_t;

  // Clamp one axis sample to plus or minus 1.0.
  function automatic logic signed [15:0] clamp_axis(input logic signed [15:0] v);
    logic signed [15:0] r;
    if (v < AXIS_NEG_ONE) r = AXIS_NEG_ONE;
    else if (v > AXIS_POS_ONE) r = AXIS_POS_ONE;
    else r = v;
    return r;
  endfunction

  // One low-pass step: s + floor((t - s) * a / 65536).
  function automatic logic signed [15:0] smooth_step(input logic signed [15:0] s,
                                                      input logic signed [15:0] t,
                                                      input logic [16:0] a);
    logic signed [16:0] diff;
    logic signed [17:0] gain;
    logic signed [34:0] prod;
    logic signed [18:0] step;
    logic signed [18:0] sum;
    diff = 17'(t) - 17'(s);
    gain = signed'({1'b0, a});
    prod = 35'(diff) * 35'(gain);
    step = 19'(prod >>> 16);
    sum  = 19'(s) + step;
    return sum[15:0];
  endfunction

endpackage

### hw/rtl/gaze_link_watchdog_smoother_core.sv
// Gaze link watchdog with frame staleness check and three-axis low-pass smoothing.
//
// Usage: each input transaction is one polled sensor packet on the in_ stream.
// The block checks the magic word and valid flag, runs a staleness counter on
// the frame id, and moves three smoothed axes toward the clamped packet values
// (or toward zero while the link is down). Each packet yields one result
// transaction on the out_ stream with the link state, the smoothed axes and
// diagnostic copies of the packet checks.
// A packet accepted into the input register has its result loaded into the output
// register once that register is free, which raises out_tvalid.
// Throughput: one packet per cycle while the receiver does not stall; the state
// update for one packet is a single pass of compares and three 17x18 multiplies
// between the two registers.
// Reset (rst_n low at a clock edge) empties both registers, zeros the watchdog
// and filter state and loads the register defaults.
// When the receiver stalls, the result holds in the output register, one more
// packet can still be taken into the input register, and in_tready then drops.
// Configuration is written over the APB-style cfg_ port; the user must write it
// only while the stream is idle, as the block itself does not enforce this.
module gaze_link_watchdog_smoother_core
  import glws_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // Input stream.
  input  logic              in_tvalid,
  output logic              in_tready,
  // tdata: magic_word[31:0], frame_id[63:32], gaze_x[79:64], gaze_y[95:80],
  //        head_z[111:96]
  input  logic [111:0]      in_tdata,
  // tuser: source_present[0], packet_valid[1]
  input  logic [1:0]        in_tuser,
  // Result stream.
  output logic              out_tvalid,
  input  logic              out_tready,
  // tdata: smooth_x[15:0], smooth_y[31:16], smooth_z[47:32], raw_frame[79:48]
  output logic [79:0]       out_tdata,
  // tuser: link_up[0], magic_match[1], valid_seen[2]
  output logic [2:0]        out_tuser,
  // Configuration port.
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  // Configuration registers.
  logic [31:0] expected_magic_r;
  logic [7:0]  stale_limit_r;
  logic [16:0] smoothing_gain_r;
  logic        cfg_wr;

  // Pipeline registers and handshake.
  glws_in_t  in_r;
  logic      in_vld_r;
  glws_out_t out_r, out_nxt;
  logic      out_vld_r;
  logic      advance;
  logic      in_fire;

  // Watchdog and filter state.
  logic [31:0]        last_frame_r, last_frame_nxt;
  logic [7:0]         stale_cnt_r, stale_cnt_nxt;
  logic               conn_r, conn_nxt;
  logic signed [15:0] filt_x_r, filt_y_r, filt_z_r;
  logic signed [15:0] filt_x_nxt, filt_y_nxt, filt_z_nxt;

  // Per-packet decisions.
  logic               mm, good;
  logic signed [15:0] tx, ty, tz;
  logic [16:0]        gain;

  // APB-style register access; writes complete in the access cycle.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expected_magic_r <= EXPECTED_MAGIC_RST;
      stale_limit_r    <= STALE_LIMIT_RST;
      smoothing_gain_r <= SMOOTHING_GAIN_RST;
    end else if (cfg_wr) begin
      case (cfg_paddr)
        ADDR_EXPECTED_MAGIC: expected_magic_r <= cfg_pwdata;
        ADDR_STALE_LIMIT:    stale_limit_r    <= cfg_pwdata[7:0];
        ADDR_SMOOTHING_GAIN: smoothing_gain_r <= cfg_pwdata[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr)
      ADDR_EXPECTED_MAGIC: cfg_prdata = expected_magic_r;
      ADDR_STALE_LIMIT:    cfg_prdata = {24'd0, stale_limit_r};
      ADDR_SMOOTHING_GAIN: cfg_prdata = {15'd0, smoothing_gain_r};
      default:             cfg_prdata = 32'd0;
    endcase
  end

  // Handshake: the output register moves when empty or taken, and the input
  // register refills whenever its content moves on.
  assign advance   = !out_vld_r || out_tready;
  assign in_tready = !in_vld_r || advance;
  assign in_fire   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_r.magic_word     <= in_tdata[31:0];
      in_r.frame_id       <= in_tdata[63:32];
      in_r.gaze_x         <= in_tdata[79:64];
      in_r.gaze_y         <= in_tdata[95:80];
      in_r.head_z         <= in_tdata[111:96];
      in_r.source_present <= in_tuser[0];
      in_r.packet_valid   <= in_tuser[1];
    end
  end

  // Watchdog: check the packet and update the stale counter.
  always_comb begin
    mm             = (in_r.magic_word == expected_magic_r);
    good           = in_r.source_present && mm && in_r.packet_valid;
    last_frame_nxt = last_frame_r;
    stale_cnt_nxt  = stale_cnt_r;
    conn_nxt       = 1'b0;
    if (in_r.source_present) begin
      if (good) begin
        if (in_r.frame_id != last_frame_r) begin
          last_frame_nxt = in_r.frame_id;
          stale_cnt_nxt  = 8'd0;
        end else if (stale_cnt_r < stale_limit_r) begin
          stale_cnt_nxt = stale_cnt_r + 8'd1;
        end else begin
          stale_cnt_nxt = stale_limit_r;
        end
        conn_nxt = (stale_cnt_nxt < stale_limit_r);
      end else begin
        stale_cnt_nxt = stale_limit_r;
      end
    end
  end

  // Targets and low-pass update for the three axes.
  always_comb begin
    tx   = conn_nxt ? clamp_axis(in_r.gaze_x) : 16'sd0;
    ty   = conn_nxt ? clamp_axis(in_r.gaze_y) : 16'sd0;
    tz   = conn_nxt ? clamp_axis(in_r.head_z) : 16'sd0;
    gain = (smoothing_gain_r > GAIN_ONE) ? GAIN_ONE : smoothing_gain_r;
    filt_x_nxt = smooth_step(filt_x_r, tx, gain);
    filt_y_nxt = smooth_step(filt_y_r, ty, gain);
    filt_z_nxt = smooth_step(filt_z_r, tz, gain);
  end

  // Result assembly; diagnostics read as zero while the source is absent.
  always_comb begin
    out_nxt.link_up     = conn_nxt;
    out_nxt.magic_match = in_r.source_present && mm;
    out_nxt.valid_seen  = in_r.source_present && in_r.packet_valid;
    out_nxt.smooth_x    = filt_x_nxt;
    out_nxt.smooth_y    = filt_y_nxt;
    out_nxt.smooth_z    = filt_z_nxt;
    out_nxt.raw_frame   = in_r.source_present ? in_r.frame_id : 32'd0;
  end

  // State and output register update when a packet leaves the input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_frame_r <= 32'd0;
      stale_cnt_r  <= 8'd0;
      conn_r       <= 1'b0;
      filt_x_r     <= 16'sd0;
      filt_y_r     <= 16'sd0;
      filt_z_r     <= 16'sd0;
      out_vld_r    <= 1'b0;
    end else begin
      if (advance) begin
        out_vld_r <= in_vld_r;
      end
      if (in_vld_r && advance) begin
        last_frame_r <= last_frame_nxt;
        stale_cnt_r  <= stale_cnt_nxt;
        conn_r       <= conn_nxt;
        filt_x_r     <= filt_x_nxt;
        filt_y_r     <= filt_y_nxt;
        filt_z_r     <= filt_z_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_vld_r && advance) begin
      out_r <= out_nxt;
    end
  end

  // Output ports.
  assign out_tvalid = out_vld_r;
  assign out_tdata  = {out_r.raw_frame, out_r.smooth_z, out_r.smooth_y, out_r.smooth_x};
  assign out_tuser  = {out_r.valid_seen, out_r.magic_match, conn_r && out_r.link_up};

`ifndef SYNTHESIS
  // A packet held in the input register is not dropped while the output stalls.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld_r && !advance) |=> in_vld_r)
    else $error("input register lost a packet during a stall");

  // A connected result always comes from a good packet.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> (out_tuser[1] && out_tuser[2]))
    else $error("link up reported for a bad packet");

  // The filter state never leaves plus or minus 1.0.
  assert property (@(posedge clk) disable iff (!rst_n)
    (filt_x_r >= AXIS_NEG_ONE && filt_x_r <= AXIS_POS_ONE &&
     filt_y_r >= AXIS_NEG_ONE && filt_y_r <= AXIS_POS_ONE &&
     filt_z_r >= AXIS_NEG_ONE && filt_z_r <= AXIS_POS_ONE))
    else $error("smoothed axis out of range");
`endif

endmodule

### bench/gaze_link_watchdog_smoother_core_tb.sv
// Testbench for the gaze link watchdog and smoother core.
`timescale 1ns / 1ps

module gaze_link_watchdog_smoother_core_tb;
  import glws_pkg::*;

  // The slowest correct run stays well under this quiet limit, even with both sides idling.
  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned MAX_REPORTS = 10;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  // tdata: magic_word[31:0], frame_id[63:32], gaze_x[79:64], gaze_y[95:80], head_z[111:96]
  logic [111:0]      in_tdata = '0;
  // tuser: source_present[0], packet_valid[1]
  logic [1:0]        in_tuser = '0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  // tdata: smooth_x[15:0], smooth_y[31:16], smooth_z[47:32], raw_frame[79:48]
  logic [79:0]       out_tdata;
  // tuser: link_up[0], magic_match[1], valid_seen[2]
  logic [2:0]        out_tuser;
  logic              cfg_psel = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr = '0;
  logic [31:0]       cfg_pwdata = '0;
  logic [31:0]       cfg_prdata;
  logic              cfg_pready;

  gaze_link_watchdog_smoother_core u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor copy of the registers and of the watchdog and filter state.
  logic [31:0]        cfg_magic = EXPECTED_MAGIC_RST;
  logic [7:0]         cfg_stale_limit = STALE_LIMIT_RST;
  logic [16:0]        cfg_gain = SMOOTHING_GAIN_RST;
  logic [31:0]        seen_frame = '0;
  logic [7:0]         stale_run = '0;
  logic               link_state = 1'b0;
  logic signed [15:0] glide_x = '0;
  logic signed [15:0] glide_y = '0;
  logic signed [15:0] glide_z = '0;

  glws_out_t pending_results[$];
  int unsigned error_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned quiet_cycles = 0;
  glws_out_t got_result;
  glws_out_t want_result;

  // Limit one raw axis sample to plus or minus 1.0.
  function automatic logic signed [15:0] limit_axis(input logic signed [15:0] v);
    if (v < AXIS_NEG_ONE) return AXIS_NEG_ONE;
    if (v > AXIS_POS_ONE) return AXIS_POS_ONE;
    return v;
  endfunction

  // One low-pass move toward the target, rounding the step toward minus infinity.
  function automatic logic signed [15:0] glide_axis(input logic signed [15:0] s,
                                                   input logic signed [15:0] t,
                                                   input logic [16:0] a);
    longint step;
    step = (longint'(t) - longint'(s)) * longint'(a);
    return 16'(longint'(s) + (step >>> 16));
  endfunction

  // Advance the predicted state by one packet and return the result it yields.
  function automatic glws_out_t predict_result(input glws_in_t p);
    glws_out_t r;
    logic signed [15:0] tx;
    logic signed [15:0] ty;
    logic signed [15:0] tz;
    logic [16:0] a;
    r = '0;
    tx = '0;
    ty = '0;
    tz = '0;
    if (p.source_present) begin
      r.magic_match = (p.magic_word == cfg_magic);
      r.valid_seen = p.packet_valid;
      r.raw_frame = p.frame_id;
      if (r.magic_match && r.valid_seen) begin
        if (p.frame_id != seen_frame) begin
          seen_frame = p.frame_id;
          stale_run = '0;
        end else if (stale_run < cfg_stale_limit) begin
          stale_run = stale_run + 8'd1;
        end else begin
          stale_run = cfg_stale_limit;
        end
        link_state = (stale_run < cfg_stale_limit);
        if (link_state) begin
          tx = limit_axis(p.gaze_x);
          ty = limit_axis(p.gaze_y);
          tz = limit_axis(p.head_z);
        end
      end else begin
        stale_run = cfg_stale_limit;
        link_state = 1'b0;
      end
    end else begin
      link_state = 1'b0;
    end
    a = (cfg_gain > GAIN_ONE) ? GAIN_ONE : cfg_gain;
    glide_x = glide_axis(glide_x, tx, a);
    glide_y = glide_axis(glide_y, ty, a);
    glide_z = glide_axis(glide_z, tz, a);
    r.link_up = link_state;
    r.smooth_x = glide_x;
    r.smooth_y = glide_y;
    r.smooth_z = glide_z;
    return r;
  endfunction

  function automatic glws_in_t make_packet(input logic present, input logic valid,
                                           input logic [31:0] magic, input logic [31:0] frame,
                                           input logic [15:0] x, input logic [15:0] y,
                                           input logic [15:0] z);
    glws_in_t p;
    p.source_present = present;
    p.packet_valid = valid;
    p.magic_word = magic;
    p.frame_id = frame;
    p.gaze_x = x;
    p.gaze_y = y;
    p.head_z = z;
    return p;
  endfunction

  task automatic note_error(input string what, input longint unsigned want,
                            input longint unsigned got);
    error_count++;
    if (error_count <= MAX_REPORTS)
      $display("[%0t] mismatch on %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
  endtask

  // Offer one packet, with random idle cycles first, and hold it until the transaction.
  task automatic send_packet(input glws_in_t p);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {p.head_z, p.gaze_y, p.gaze_x, p.frame_id, p.magic_word};
    in_tuser <= {p.packet_valid, p.source_present};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_results.push_back(predict_result(p));
  endtask

  // Stop offering packets and wait until every outstanding result has been checked.
  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Register write: a setup phase, then an access phase that completes when pready is high.
  task automatic write_reg(input logic [CFG_AW-1:0] addr, input logic [31:0] value);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    case (addr)
      ADDR_EXPECTED_MAGIC: cfg_magic = value;
      ADDR_STALE_LIMIT:    cfg_stale_limit = value[7:0];
      ADDR_SMOOTHING_GAIN: cfg_gain = value[16:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  task automatic write_all_regs(input logic [31:0] magic, input logic [7:0] limit,
                                input logic [16:0] gain);
    wait_drained();
    write_reg(ADDR_EXPECTED_MAGIC, magic);
    write_reg(ADDR_STALE_LIMIT, {24'd0, limit});
    write_reg(ADDR_SMOOTHING_GAIN, {15'd0, gain});
  endtask

  // Raw axis sample: mostly in range, sometimes anywhere, sometimes at the edges.
  function automatic logic [15:0] pick_axis();
    case ($urandom_range(3))
      0: return 16'($urandom);
      1: begin
        case ($urandom_range(4))
          0: return 16'h8000;
          1: return 16'h7FFF;
          2: return AXIS_POS_ONE;
          3: return AXIS_NEG_ONE;
          default: return 16'(AXIS_POS_ONE + 16'sd1);
        endcase
      end
      default: return 16'($urandom_range(32768) - 16384);
    endcase
  endfunction

  // Result checker: each result transaction is compared with the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_result.link_up = out_tuser[0];
      got_result.magic_match = out_tuser[1];
      got_result.valid_seen = out_tuser[2];
      got_result.smooth_x = out_tdata[15:0];
      got_result.smooth_y = out_tdata[31:16];
      got_result.smooth_z = out_tdata[47:32];
      got_result.raw_frame = out_tdata[79:48];
      if (pending_results.size() == 0) begin
        note_error("unexpected result", 64'd0, out_tdata[63:0]);
      end else begin
        want_result = pending_results.pop_front();
        if (got_result.link_up != want_result.link_up)
          note_error("link_up", {63'd0, want_result.link_up}, {63'd0, got_result.link_up});
        if (got_result.magic_match != want_result.magic_match)
          note_error("magic_match", {63'd0, want_result.magic_match},
                     {63'd0, got_result.magic_match});
        if (got_result.valid_seen != want_result.valid_seen)
          note_error("valid_seen", {63'd0, want_result.valid_seen},
                     {63'd0, got_result.valid_seen});
        if (got_result.smooth_x != want_result.smooth_x)
          note_error("smooth_x", {48'd0, want_result.smooth_x}, {48'd0, got_result.smooth_x});
        if (got_result.smooth_y != want_result.smooth_y)
          note_error("smooth_y", {48'd0, want_result.smooth_y}, {48'd0, got_result.smooth_y});
        if (got_result.smooth_z != want_result.smooth_z)
          note_error("smooth_z", {48'd0, want_result.smooth_z}, {48'd0, got_result.smooth_z});
        if (got_result.raw_frame != want_result.raw_frame)
          note_error("raw_frame", {32'd0, want_result.raw_frame},
                     {32'd0, got_result.raw_frame});
      end
    end
  end

  // Receiver: stalls at random with the current stall percentage.
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog: ends the run when nothing moves on any port for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_psel && cfg_penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Default registers: frame id zero, source absent, bad magic and cleared valid flag.
  task automatic test_reset_defaults();
    send_packet(make_packet(1'b1, 1'b1, 32'd0, 32'd0, 16'd1000, -16'sd1000, 16'd0));
    send_packet(make_packet(1'b1, 1'b1, 32'd0, 32'd0, 16'd200, 16'd300, -16'sd400));
    send_packet(make_packet(1'b1, 1'b1, 32'd0, 32'd1, 16'h7FFF, 16'h8000, AXIS_POS_ONE));
    send_packet(make_packet(1'b0, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF,
                            16'hFFFF, 16'hFFFF));
    send_packet(make_packet(1'b1, 1'b1, 32'h8000_0001, 32'd2, 16'd500, 16'd500, 16'd500));
    send_packet(make_packet(1'b1, 1'b0, 32'd0, 32'd3, 16'd500, 16'd500, 16'd500));
    send_packet(make_packet(1'b1, 1'b1, 32'd0, 32'd4, AXIS_NEG_ONE, 16'd0, 16'h7FFF));
  endtask

  // Stale counter: repeated ids up to saturation, then a lowered limit below the count.
  task automatic test_watchdog_limits();
    write_all_regs(32'hFFFF_FFFF, 8'd3, GAIN_ONE);
    send_packet(make_packet(1'b1, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hBFFF, 16'h4001,
                            AXIS_NEG_ONE));
    repeat (4) begin
      send_packet(make_packet(1'b1, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd100, 16'd100,
                              16'd100));
    end
    write_all_regs(32'hFFFF_FFFF, 8'd2, GAIN_ONE);
    send_packet(make_packet(1'b1, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd100, 16'd100,
                            16'd100));
    send_packet(make_packet(1'b1, 1'b1, 32'hFFFF_FFFF, 32'h0000_0010, 16'd100, 16'd100,
                            16'd100));
    // With a zero limit even a fresh frame leaves the link down.
    write_all_regs(32'h5A5A_A5A5, 8'd0, GAIN_ONE);
    send_packet(make_packet(1'b1, 1'b1, 32'h5A5A_A5A5, 32'h0000_0020, 16'd100, 16'd100,
                            16'd100));
  endtask

  // Gain: above unity, zero, and the smallest nonzero value that still rounds down.
  task automatic test_gain_extremes();
    write_all_regs(32'h5A5A_A5A5, 8'd255, 17'h1FFFF);
    send_packet(make_packet(1'b1, 1'b1, 32'h5A5A_A5A5, 32'h0000_0030, AXIS_POS_ONE,
                            AXIS_NEG_ONE, 16'd1234));
    write_all_regs(32'h5A5A_A5A5, 8'd255, 17'd0);
    send_packet(make_packet(1'b1, 1'b1, 32'h5A5A_A5A5, 32'h0000_0031, AXIS_NEG_ONE,
                            AXIS_POS_ONE, 16'd0));
    write_all_regs(32'h5A5A_A5A5, 8'd255, 17'd1);
    send_packet(make_packet(1'b1, 1'b1, 32'h5A5A_A5A5, 32'h0000_0032, 16'h8000, 16'h7FFF,
                            16'h8000));
    send_packet(make_packet(1'b1, 1'b1, 32'h0000_0000, 32'h0000_0033, 16'd0, 16'd0, 16'd0));
  endtask

  // Random traffic under one idling pattern, in three register settings.
  task automatic test_random_traffic(input int unsigned idle_pct, input int unsigned stall_pct,
                                     input int unsigned count);
    logic [7:0]  limit;
    logic [16:0] gain;
    logic [31:0] magic;
    logic [31:0] frame;
    int unsigned kind;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (int s = 0; s < 3; s++) begin
      case ($urandom_range(5))
        0: limit = 8'd0;
        1: limit = 8'd1;
        2: limit = 8'd255;
        default: limit = 8'($urandom_range(2, 8));
      endcase
      case ($urandom_range(7))
        0: gain = 17'd0;
        1: gain = GAIN_ONE;
        2: gain = 17'($urandom_range(65537, 131071));
        3: gain = 17'h1FFFF;
        default: gain = 17'($urandom_range(1, 65535));
      endcase
      write_all_regs($urandom, limit, gain);
      for (int n = 0; n < count / 3; n++) begin
        kind = $urandom_range(99);
        frame = ($urandom_range(99) < 50) ? seen_frame : $urandom;
        magic = cfg_magic;
        if (kind >= 78 && kind < 88) begin
          // Wrong magic: one flipped bit or a whole new word.
          magic = ($urandom_range(1) == 0) ? cfg_magic ^ (32'd1 << $urandom_range(31)) : $urandom;
          if (magic == cfg_magic) magic = ~magic;
        end else if (kind >= 95) begin
          magic = $urandom;
        end
        send_packet(make_packet(!(kind >= 70 && kind < 78) || kind >= 95 ? 1'b1 :
                                (kind >= 95 ? 1'($urandom) : 1'b0),
                                (kind >= 88 && kind < 95) ? 1'b0 :
                                (kind >= 95 ? 1'($urandom) : 1'b1),
                                magic, frame, pick_axis(), pick_axis(), pick_axis()));
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_watchdog_limits();
    test_gain_extremes();
    test_random_traffic(0, 0, 288);
    test_random_traffic(75, 0, 288);
    test_random_traffic(0, 75, 288);
    test_random_traffic(14, 14, 288);
    wait_drained();
    repeat (4) @(posedge clk);
    if (pending_results.size() != 0) error_count++;
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/glws_pkg.sv
hw/rtl/gaze_link_watchdog_smoother_core.sv
bench/gaze_link_watchdog_smoother_core_tb.sv
